### rtl/rddt_pkg.sv
// Shared widths and command codes for the relay delay/duration timer.
package rddt_pkg;

   localparam int COUNT_W = 16;          // delay, work and scale fields
   localparam int TIME_W  = 32;          // tick counter and wait times
   localparam int RELAY_W = 4;           // relay number nibble
   localparam int CODE_W  = 4;           // command code nibble
   localparam int MASK_W  = 4;           // relays shown on the output

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [TIME_W-1:0]  time_type;

   // action field
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_CMD  = 1'b1;

   // do_code field
   localparam logic [CODE_W-1:0] DO_OFF_AFTER = 4'd0;
   localparam logic [CODE_W-1:0] DO_DELAY_ON  = 4'd1;

endpackage

### rtl/relay_delay_duration_timer.sv
// Relay delay/duration timer: tick counter, per-relay on/off timers and relay mask.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  action, relay_field, do_code,
//                                            delay_count, work_count, scale
//   rsp      out        rsp_valid/rsp_stall  relay_mask, switch_event
//
// A req beat passes through an input register, then the per-relay multiply/
// compare logic that updates timer state and loads the result register. One
// beat per cycle is sustained while rsp_stall is low; the 16x16 products and
// the 32-bit elapsed-time compares of all relays sit in that single stage.
// Synchronous reset clears the tick counter, relay bits and relay modes.
// rsp_stall holds the result register and, with it full, the input register.
module relay_delay_duration_timer #(
   parameter int NUM_RELAYS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [rddt_pkg::RELAY_W-1:0]  req_relay_field,
   input  logic [rddt_pkg::CODE_W-1:0]   req_do_code,
   input  logic [rddt_pkg::COUNT_W-1:0]  req_delay_count,
   input  logic [rddt_pkg::COUNT_W-1:0]  req_work_count,
   input  logic [rddt_pkg::COUNT_W-1:0]  req_scale,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rddt_pkg::MASK_W-1:0]   rsp_relay_mask,
   output logic                          rsp_switch_event
);
   import rddt_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_OFF,
      MODE_ON
   } mode_type;

   // input register
   logic                in_vld_ff;
   logic                in_action_ff;
   logic [RELAY_W-1:0]  in_relay_ff;
   logic [CODE_W-1:0]   in_code_ff;
   count_type           in_delay_ff;
   count_type           in_work_ff;
   count_type           in_scale_ff;

   // result register
   logic                out_vld_ff;
   logic [MASK_W-1:0]   out_mask_ff;
   logic                out_event_ff;

   // timer state
   time_type                tick_ff;
   time_type                tick_in;
   logic [NUM_RELAYS-1:0]   relay_bits_ff;
   logic [NUM_RELAYS-1:0]   relay_bits_in;
   logic [NUM_RELAYS-1:0]   fire_off;
   logic [NUM_RELAYS-1:0]   fire_on;
   logic [NUM_RELAYS+MASK_W-1:0] mask_pad;

   logic     advance;
   logic     step;
   logic     is_tick;
   logic     code_ok;
   time_type dly_prod;
   time_type wrk_prod;

   assign advance   = !out_vld_ff || !rsp_stall;
   assign req_stall = in_vld_ff && !advance;
   assign step      = in_vld_ff && advance;
   assign is_tick   = step && (in_action_ff == ACT_TICK);
   assign code_ok   = (in_code_ff == DO_OFF_AFTER) || (in_code_ff == DO_DELAY_ON);
   assign tick_in   = tick_ff + TIME_W'(1);
   assign dly_prod  = TIME_W'(in_delay_ff) * TIME_W'(in_scale_ff);
   assign wrk_prod  = TIME_W'(in_work_ff) * TIME_W'(in_scale_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_action_ff <= req_action;
         in_relay_ff  <= req_relay_field;
         in_code_ff   <= req_do_code;
         in_delay_ff  <= req_delay_count;
         in_work_ff   <= req_work_count;
         in_scale_ff  <= req_scale;
      end
   end

   for (genvar ch = 0; ch < NUM_RELAYS; ch++) begin : g_chan
      localparam logic [RELAY_W-1:0] CH_ID = RELAY_W'(ch + 1);

      mode_type mode_ff;
      time_type on_start_ff;
      time_type off_start_ff;
      time_type on_wait_ff;
      time_type off_wait_ff;
      logic     arm;

      assign arm = step && (in_action_ff == ACT_CMD) && (in_relay_ff == CH_ID) && code_ok;

      // mode is checked before update, so off and on firing are exclusive
      assign fire_off[ch] = is_tick && (mode_ff == MODE_OFF) &&
                            ((tick_in - off_start_ff) >= off_wait_ff);
      assign fire_on[ch]  = is_tick && (mode_ff == MODE_ON) &&
                            ((tick_in - on_start_ff) >= on_wait_ff);

      always_ff @(posedge clock) begin
         if (reset) begin
            mode_ff <= MODE_IDLE;
         end else if (arm) begin
            mode_ff <= (in_code_ff == DO_OFF_AFTER) ? MODE_OFF : MODE_ON;
         end else if (fire_off[ch]) begin
            mode_ff <= MODE_IDLE;
         end else if (fire_on[ch]) begin
            mode_ff <= (off_wait_ff != '0) ? MODE_OFF : MODE_IDLE;
         end
         if (arm) begin
            off_wait_ff  <= wrk_prod;
            on_start_ff  <= tick_ff;
            off_start_ff <= tick_ff;
            if (in_code_ff == DO_DELAY_ON) begin
               on_wait_ff <= dly_prod;
            end
         end else if (fire_on[ch] && (off_wait_ff != '0)) begin
            off_start_ff <= tick_in;
         end
      end
   end

   always_comb begin
      relay_bits_in = relay_bits_ff;
      for (int i = 0; i < NUM_RELAYS; i++) begin
         if (fire_off[i]) begin
            relay_bits_in[i] = 1'b0;
         end else if (fire_on[i]) begin
            relay_bits_in[i] = 1'b1;
         end
      end
   end

   // only relays 1..4 reach the output; pad when fewer are built
   assign mask_pad = {{MASK_W{1'b0}}, relay_bits_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         relay_bits_ff <= '0;
         out_vld_ff    <= 1'b0;
      end else begin
         if (is_tick) begin
            tick_ff       <= tick_in;
            relay_bits_ff <= relay_bits_in;
         end
         if (step) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
      if (step) begin
         out_mask_ff  <= mask_pad[MASK_W-1:0];
         out_event_ff <= |(fire_off | fire_on);
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_relay_mask   = out_mask_ff;
   assign rsp_switch_event = out_event_ff;

endmodule

### tb/sv/relay_delay_duration_timer_tb.sv
// Testbench for the relay delay/duration timer: directed and random beats, scoreboard check.
`timescale 1ns / 100ps

module relay_delay_duration_timer_tb;
   import rddt_pkg::*;

   localparam int RELAYS       = 4;
   localparam int RANDOM_BEATS = 1050;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 8;

   // receiver stall patterns
   localparam int RX_FREE   = 0;
   localparam int RX_RANDOM = 1;
   localparam int RX_BURSTY = 2;

   typedef enum logic [1:0] {
      CH_IDLE      = 2'd0,
      CH_OFF_ARMED = 2'd1,
      CH_ON_ARMED  = 2'd2
   } chan_mode_type;

   typedef struct packed {
      logic              action;
      logic [RELAY_W-1:0] relay;
      logic [CODE_W-1:0]  code;
      count_type          dly;
      count_type          wrk;
      count_type          scl;
   } req_beat_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic              fired;
   } relay_out_type;

   function automatic logic cmd_ignored(input req_beat_type b);
      return b.action == ACT_CMD &&
             !(b.relay >= 1 && b.relay <= RELAYS &&
               (b.code == DO_OFF_AFTER || b.code == DO_DELAY_ON));
   endfunction

   class relay_timer_scoreboard;
      time_type       ticks;
      chan_mode_type  mode [RELAYS];
      time_type       on_mark [RELAYS];
      time_type       off_mark [RELAYS];
      time_type       on_len [RELAYS];
      time_type       off_len [RELAYS];
      logic [RELAYS-1:0] relays;
      relay_out_type  due_outputs [$];
      int             failures;
      int             reported;

      function new();
         ticks  = '0;
         relays = '0;
         for (int ch = 0; ch < RELAYS; ch++) begin
            mode[ch]     = CH_IDLE;
            on_mark[ch]  = '0;
            off_mark[ch] = '0;
            on_len[ch]   = '0;
            off_len[ch]  = '0;
         end
         failures = 0;
         reported = 0;
      endfunction

      // predict the output for one accepted input beat
      function void apply_beat(input req_beat_type b);
         logic fired;
         int   ch;
         fired = 1'b0;
         if (b.action == ACT_CMD) begin
            if (!cmd_ignored(b)) begin
               ch = int'(b.relay) - 1;
               off_len[ch]  = time_type'(b.wrk) * time_type'(b.scl);
               on_mark[ch]  = ticks;
               off_mark[ch] = ticks;
               if (b.code == DO_OFF_AFTER) begin
                  mode[ch] = CH_OFF_ARMED;
               end else begin
                  on_len[ch] = time_type'(b.dly) * time_type'(b.scl);
                  mode[ch]   = CH_ON_ARMED;
               end
            end
         end else begin
            ticks = ticks + 1;
            for (ch = 0; ch < RELAYS; ch++) begin
               // off check first; a fresh off arm waits for the next tick
               if (mode[ch] == CH_OFF_ARMED &&
                   time_type'(ticks - off_mark[ch]) >= off_len[ch]) begin
                  mode[ch]   = CH_IDLE;
                  relays[ch] = 1'b0;
                  fired      = 1'b1;
               end
               if (mode[ch] == CH_ON_ARMED &&
                   time_type'(ticks - on_mark[ch]) >= on_len[ch]) begin
                  mode[ch]   = CH_IDLE;
                  relays[ch] = 1'b1;
                  fired      = 1'b1;
                  if (off_len[ch] != 0) begin
                     mode[ch]     = CH_OFF_ARMED;
                     off_mark[ch] = ticks;
                  end
               end
            end
         end
         due_outputs.push_back(relay_out_type'{mask: MASK_W'(relays), fired: fired});
      endfunction

      function void check_output(input logic [MASK_W-1:0] mask, input logic fired);
         relay_out_type exp_out;
         if (due_outputs.size() == 0) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("unexpected rsp beat: relay_mask=%h switch_event=%b", mask, fired);
            end
            return;
         end
         exp_out = due_outputs.pop_front();
         if (mask !== exp_out.mask || fired !== exp_out.fired) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("rsp mismatch: relay_mask exp %h got %h, switch_event exp %b got %b",
                        exp_out.mask, mask, exp_out.fired, fired);
            end
         end
      endfunction

      function int pending();
         return due_outputs.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_action = 1'b0;
   logic [RELAY_W-1:0] req_relay_field = '0;
   logic [CODE_W-1:0]  req_do_code = '0;
   count_type          req_delay_count = '0;
   count_type          req_work_count = '0;
   count_type          req_scale = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [MASK_W-1:0] rsp_relay_mask;
   logic              rsp_switch_event;

   relay_timer_scoreboard sb = new();

   int rx_mode = RX_FREE;
   int rx_phase_left = 0;
   int rx_run_left = 0;
   int idle_cycles;
   int sent_beats;
   int burst_left;
   int gap;

   relay_delay_duration_timer #(.NUM_RELAYS(RELAYS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_relay_field (req_relay_field),
      .req_do_code     (req_do_code),
      .req_delay_count (req_delay_count),
      .req_work_count  (req_work_count),
      .req_scale       (req_scale),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_relay_mask  (rsp_relay_mask),
      .rsp_switch_event(rsp_switch_event)
   );

   always #4 clock = ~clock;

   function automatic req_beat_type tick_beat();
      req_beat_type b;
      b = '0;
      b.action = ACT_TICK;
      return b;
   endfunction

   function automatic req_beat_type cmd_beat(input int relay, input logic [CODE_W-1:0] code,
                                             input int dly, input int wrk, input int scl);
      req_beat_type b;
      b.action = ACT_CMD;
      b.relay  = RELAY_W'(relay);
      b.code   = code;
      b.dly    = COUNT_W'(dly);
      b.wrk    = COUNT_W'(wrk);
      b.scl    = COUNT_W'(scl);
      return b;
   endfunction

   function automatic req_beat_type random_beat();
      req_beat_type b;
      int roll;
      roll = $urandom_range(0, 99);
      // unused fields still carry random noise
      b.action = ACT_CMD;
      b.relay  = RELAY_W'($urandom);
      b.code   = CODE_W'($urandom);
      b.dly    = COUNT_W'($urandom);
      b.wrk    = COUNT_W'($urandom);
      b.scl    = COUNT_W'($urandom);
      b.relay  = RELAY_W'($urandom_range(1, RELAYS));
      b.code   = $urandom_range(0, 1) ? DO_DELAY_ON : DO_OFF_AFTER;
      if (roll < 55) begin
         b.action = ACT_TICK;
      end else if (roll < 80) begin
         // short timers so channels actually fire
         b.dly = COUNT_W'($urandom_range(0, 6));
         b.wrk = COUNT_W'($urandom_range(0, 6));
         b.scl = COUNT_W'($urandom_range(0, 4));
      end else if (roll < 86) begin
         b.dly = '0;
         b.wrk = COUNT_W'($urandom_range(0, 1)) * COUNT_W'($urandom_range(0, 1));
         if (b.wrk != 0 && b.scl > 8)
            b.scl = COUNT_W'($urandom_range(1, 8));
      end else if (roll < 92) begin
         ; // full-range counts: long timers, normally overwritten later
      end else begin
         b.relay = RELAY_W'($urandom);
         b.code  = CODE_W'($urandom);
         if (!cmd_ignored(b))
            b.code = CODE_W'($urandom_range(2, 15));
      end
      return b;
   endfunction

   task automatic send_beat(input req_beat_type b);
      req_valid       <= 1'b1;
      req_action      <= b.action;
      req_relay_field <= b.relay;
      req_do_code     <= b.code;
      req_delay_count <= b.dly;
      req_work_count  <= b.wrk;
      req_scale       <= b.scl;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      sb.apply_beat(b);
   endtask

   // result side: check beats and drive the stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         sb.check_output(rsp_relay_mask, rsp_switch_event);
      if (rx_phase_left == 0) begin
         rx_mode       = $urandom_range(RX_FREE, RX_BURSTY);
         rx_phase_left = $urandom_range(20, 120);
      end
      rx_phase_left--;
      case (rx_mode)
         RX_RANDOM: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         RX_BURSTY: begin
            if (rx_run_left > 0) begin
               rsp_stall <= 1'b1;
               rx_run_left--;
            end else begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 4) == 0)
                  rx_run_left = $urandom_range(1, 15);
            end
         end
         default: begin
            rsp_stall <= 1'b0;
         end
      endcase
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("relay_delay_duration_timer regression: fail");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed beats
      send_beat(tick_beat());
      send_beat(cmd_beat(1, DO_DELAY_ON, 0, 0, 0));         // on at next tick, no off
      send_beat(tick_beat());
      send_beat(cmd_beat(0, DO_DELAY_ON, 16'hffff, 16'hffff, 16'hffff));
      send_beat(cmd_beat(5, DO_DELAY_ON, 0, 0, 0));
      send_beat(cmd_beat(15, DO_OFF_AFTER, 0, 0, 0));
      send_beat(cmd_beat(2, CODE_W'(2), 0, 0, 0));
      send_beat(cmd_beat(3, CODE_W'(15), 0, 0, 0));
      send_beat(cmd_beat(2, DO_OFF_AFTER, 16'hffff, 2, 1));  // relay already off
      send_beat(cmd_beat(3, DO_DELAY_ON, 1, 1, 2));
      send_beat(cmd_beat(4, DO_DELAY_ON, 16'hffff, 16'hffff, 16'hffff));
      send_beat(cmd_beat(1, DO_DELAY_ON, 0, 1, 1));          // on, then off one tick later
      send_beat(tick_beat());
      send_beat(tick_beat());
      send_beat(cmd_beat(1, DO_OFF_AFTER, 16'h5555, 0, 16'haaaa)); // off at next tick
      send_beat(cmd_beat(2, DO_DELAY_ON, 0, 0, 16'hffff));
      send_beat(tick_beat());
      send_beat(tick_beat());
      send_beat(tick_beat());
      send_beat(cmd_beat(2, DO_DELAY_ON, 0, 0, 0));          // on while already on
      send_beat(cmd_beat(4, DO_OFF_AFTER, 0, 0, 0));
      send_beat(tick_beat());
      send_beat(tick_beat());

      // random beats in bursts
      sent_beats = 0;
      burst_left = $urandom_range(1, 20);
      while (sent_beats < RANDOM_BEATS) begin
         req_beat_type b;
         b = random_beat();
         send_beat(b);
         sent_beats++;
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0 && sb.pending() == 0)
         $display("relay_delay_duration_timer regression: pass");
      else
         $display("relay_delay_duration_timer regression: fail");
      $finish;
   end

endmodule
